// ===== src/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types, widths and codes of the bilinear resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package brs_pkg;

    // geometry and number format
    localparam int COORD_W   = 8;
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int SIZE_W    = 9;
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int MAX_COLS  = 256;
    localparam int MAX_ROWS  = 256;

    // divider: dividend is position numerator shifted by the fraction
    localparam int NUM_W  = 2 * COORD_W;
    localparam int DIVN_W = NUM_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(DIVN_W + 1);

    // interpolation datapath
    localparam int P_W    = VAL_W + 3;
    localparam int B_W    = VAL_W + 6;
    localparam int WF_W   = FRAC_BITS + 1;
    localparam int PROD_W = WF_W + 1 + B_W;
    localparam int ACC_W  = PROD_W + 1;

    // apb address map
    localparam int PADDR_W = 5;

    typedef enum logic [2:0] {
        REG_SRC_COLS  = 3'd0,
        REG_SRC_ROWS  = 3'd1,
        REG_DST_COLS  = 3'd2,
        REG_DST_ROWS  = 3'd3,
        REG_MASK_EN   = 3'd4,
        REG_MASK_LOW  = 3'd5,
        REG_MASK_HIGH = 3'd6,
        REG_NONE      = 3'd7
    } reg_idx_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_POST,
        ST_READ,
        ST_EXTRA,
        ST_MUL,
        ST_OUT
    } state_t;

    // size register with zero treated as one and capped
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] cap);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > cap)
            r = cap;
        return r;
    endfunction

    // round half up on the fraction, floor semantics
    function automatic logic signed [B_W-1:0] round_frac(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return t[B_W-1:0];
    endfunction

    // saturate to the signed result range: upper bits must all match the sign
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [B_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        r = v[VAL_W-1:0];
        if (v[B_W-1:VAL_W-1] != {(B_W-VAL_W+1){v[B_W-1]}})
            r = v[B_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/brs_div.sv =====
// ----------------------------------------------------------------------------
// brs_div
// Restoring divider, one quotient bit per cycle, for the source position.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [brs_pkg::DIVN_W-1:0]    dividend,
    input  wire logic [brs_pkg::SIZE_W-1:0]    divisor,
    output logic                               busy,
    output logic [brs_pkg::DIVN_W-1:0]         quotient
);

    logic [brs_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic [brs_pkg::DIVN_W-1:0] quo_reg, quo_next;
    logic [brs_pkg::SIZE_W-1:0] rem_reg, rem_next;
    logic [brs_pkg::SIZE_W:0]   rem_sh;

    // one restoring step
    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        rem_sh   = {rem_reg, quo_reg[brs_pkg::DIVN_W-1]};
        if (start)
        begin
            cnt_next = brs_pkg::DCNT_W'(brs_pkg::DIVN_W);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - brs_pkg::DCNT_W'(1);
            if (rem_sh >= {1'b0, divisor})
            begin
                rem_next = brs_pkg::SIZE_W'(rem_sh - {1'b0, divisor});
                quo_next = {quo_reg[brs_pkg::DIVN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[brs_pkg::SIZE_W-1:0];
                quo_next = {quo_reg[brs_pkg::DIVN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/bilinear_resampler_nodata.sv =====
// ----------------------------------------------------------------------------
// bilinear_resampler_nodata
// Image store with masked loads and bilinear queries with no-data handling.
// ----------------------------------------------------------------------------
// load: written in the cycle it is accepted, one per cycle while no query is in progress
// query: bit-serial position divide, position split, four reads of the single store port,
// no-data check, shared multiplier, then the result is loaded to the output register;
// a no-data result skips the multiplier
// one query at a time; a waiting result holds the next query
// reset clears control and configuration only; the store is not cleared
`default_nettype none

module bilinear_resampler_nodata (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // apb configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [brs_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [31:0]                        pwdata,
    output logic      [31:0]                        prdata,
    output logic                                    pready,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               operation,
    input  wire logic [brs_pkg::COORD_W-1:0]        col,
    input  wire logic [brs_pkg::COORD_W-1:0]        row,
    input  wire logic signed [brs_pkg::VAL_W-1:0]   pixel_value,
    input  wire logic                               pixel_nodata,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [brs_pkg::VAL_W-1:0]        result_value,
    output logic                                    result_nodata,
    output logic      [brs_pkg::COORD_W-1:0]        result_col,
    output logic      [brs_pkg::COORD_W-1:0]        result_row
);

    localparam int VW = brs_pkg::VAL_W;
    localparam int CW = brs_pkg::COORD_W;
    localparam int SW = brs_pkg::SIZE_W;
    localparam logic [brs_pkg::WF_W-1:0] W_ONE = brs_pkg::WF_W'(1 << brs_pkg::FRAC_BITS);

    // configuration registers
    logic [SW-1:0]        src_cols_reg, src_rows_reg, dst_cols_reg, dst_rows_reg;
    logic                 mask_en_reg;
    logic signed [VW-1:0] mask_low_reg, mask_high_reg;
    brs_pkg::reg_idx_t    cfg_idx;
    logic                 cfg_wr;

    assign cfg_idx = brs_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_cols_reg  <= SW'(256);
            src_rows_reg  <= SW'(256);
            dst_cols_reg  <= SW'(256);
            dst_rows_reg  <= SW'(256);
            mask_en_reg   <= 1'b0;
            mask_low_reg  <= '0;
            mask_high_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                brs_pkg::REG_SRC_COLS:  src_cols_reg  <= pwdata[SW-1:0];
                brs_pkg::REG_SRC_ROWS:  src_rows_reg  <= pwdata[SW-1:0];
                brs_pkg::REG_DST_COLS:  dst_cols_reg  <= pwdata[SW-1:0];
                brs_pkg::REG_DST_ROWS:  dst_rows_reg  <= pwdata[SW-1:0];
                brs_pkg::REG_MASK_EN:   mask_en_reg   <= pwdata[0];
                brs_pkg::REG_MASK_LOW:  mask_low_reg  <= pwdata[VW-1:0];
                brs_pkg::REG_MASK_HIGH: mask_high_reg <= pwdata[VW-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (cfg_idx)
            brs_pkg::REG_SRC_COLS:  prdata = 32'(src_cols_reg);
            brs_pkg::REG_SRC_ROWS:  prdata = 32'(src_rows_reg);
            brs_pkg::REG_DST_COLS:  prdata = 32'(dst_cols_reg);
            brs_pkg::REG_DST_ROWS:  prdata = 32'(dst_rows_reg);
            brs_pkg::REG_MASK_EN:   prdata = 32'(mask_en_reg);
            brs_pkg::REG_MASK_LOW:  prdata = mask_low_reg;
            brs_pkg::REG_MASK_HIGH: prdata = mask_high_reg;
            default:                prdata = '0;
        endcase
    end

    // effective sizes
    logic [SW-1:0] sc, sr, dc, dr;
    logic [CW-1:0] sc_m1, sr_m1;
    assign sc    = brs_pkg::eff_size(src_cols_reg, SW'(brs_pkg::MAX_COLS));
    assign sr    = brs_pkg::eff_size(src_rows_reg, SW'(brs_pkg::MAX_ROWS));
    assign dc    = brs_pkg::eff_size(dst_cols_reg, {SW{1'b1}});
    assign dr    = brs_pkg::eff_size(dst_rows_reg, {SW{1'b1}});
    assign sc_m1 = CW'(sc - SW'(1));
    assign sr_m1 = CW'(sr - SW'(1));

    // control
    brs_pkg::state_t state_reg, state_next;
    logic [2:0]      phase_reg;
    logic            in_acc, load_acc, query_acc, div_start, res_load;
    logic            busy_x, busy_y;
    logic            nodata_next;

    assign in_acc    = in_valid && !in_stall;
    assign load_acc  = in_acc && (brs_pkg::op_t'(operation) == brs_pkg::OP_LOAD);
    assign query_acc = in_acc && (brs_pkg::op_t'(operation) == brs_pkg::OP_QUERY);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brs_pkg::ST_IDLE:  if (query_acc) state_next = brs_pkg::ST_DIV;
            brs_pkg::ST_DIV:   if (!busy_x && !busy_y) state_next = brs_pkg::ST_POST;
            brs_pkg::ST_POST:  state_next = brs_pkg::ST_READ;
            brs_pkg::ST_READ:  if (phase_reg == 3'd4) state_next = brs_pkg::ST_EXTRA;
            brs_pkg::ST_EXTRA: state_next = nodata_next ? brs_pkg::ST_OUT : brs_pkg::ST_MUL;
            brs_pkg::ST_MUL:   if (phase_reg == 3'd6) state_next = brs_pkg::ST_OUT;
            brs_pkg::ST_OUT:   if (!out_valid || !out_stall) state_next = brs_pkg::ST_IDLE;
            default:           state_next = brs_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        res_load  = 1'b0;
        case (state_reg)
            brs_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                div_start = query_acc;
            end
            brs_pkg::ST_OUT: res_load = !out_valid || !out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brs_pkg::ST_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= (state_next != state_reg) ? 3'd0 : phase_reg + 3'd1;
        end
    end

    // position dividers, one per axis
    logic [brs_pkg::DIVN_W-1:0] qx, qy;
    logic [brs_pkg::NUM_W-1:0]  num_x, num_y;
    assign num_x = brs_pkg::NUM_W'(col) * brs_pkg::NUM_W'(sc_m1);
    assign num_y = brs_pkg::NUM_W'(row) * brs_pkg::NUM_W'(sr_m1);

    brs_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({num_x, brs_pkg::FRAC_BITS'(0)}),
        .divisor  (dc - SW'(1)),
        .busy     (busy_x),
        .quotient (qx)
    );

    brs_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({num_y, brs_pkg::FRAC_BITS'(0)}),
        .divisor  (dr - SW'(1)),
        .busy     (busy_y),
        .quotient (qy)
    );

    // image store
    logic [VW:0]                  mem [0:(1 << brs_pkg::ADDR_W)-1];
    logic [VW:0]                  rd_data_reg;
    logic [brs_pkg::ADDR_W-1:0]   rd_addr;
    logic                         mask_hit;

    assign mask_hit = mask_en_reg && (pixel_value >= mask_low_reg)
                      && (pixel_value <= mask_high_reg);

    always_ff @(posedge clk)
    begin
        if (load_acc)
            mem[{row, col}] <= {pixel_nodata | mask_hit, pixel_value};
        rd_data_reg <= mem[rd_addr];
    end

    // query datapath
    logic [CW-1:0]                  col_reg, row_reg, x1_reg, y1_reg;
    logic [brs_pkg::FRAC_BITS-1:0]  fx_reg, fy_reg;
    logic [brs_pkg::NUM_W-1:0]      ix, iy;
    logic signed [brs_pkg::P_W-1:0] p_reg [0:3];
    logic [3:0]                     n_reg;
    logic [3:0]                     in_img;
    logic [1:0]                     rk, ck;
    logic [SW-1:0]                  x2, y2;
    logic                           nodata_reg;
    logic signed [brs_pkg::P_W-1:0] e0, e1, e2, e3;
    logic [2:0]                     n_cnt;
    logic signed [brs_pkg::PROD_W-1:0] prod_reg;
    logic signed [brs_pkg::ACC_W-1:0]  acc_reg, acc_sum;
    logic signed [brs_pkg::B_W-1:0]    top_reg, bot_reg, val_reg, mul_b;
    logic [brs_pkg::WF_W-1:0]          mul_a;
    logic [2:0]                        mj;

    assign ix = qx[brs_pkg::DIVN_W-1:brs_pkg::FRAC_BITS];
    assign iy = qy[brs_pkg::DIVN_W-1:brs_pkg::FRAC_BITS];
    assign x2 = SW'(x1_reg) + SW'(1);
    assign y2 = SW'(y1_reg) + SW'(1);

    // corner validity: right and bottom neighbours may lie past the edge
    assign in_img[0] = 1'b1;
    assign in_img[1] = (x2 < sc);
    assign in_img[2] = (y2 < sr);
    assign in_img[3] = (x2 < sc) && (y2 < sr);

    assign rk      = phase_reg[1:0];
    assign ck      = 2'(phase_reg - 3'd1);
    assign rd_addr = {CW'(y1_reg + CW'(rk[1])), CW'(x1_reg + CW'(rk[0]))};

    // single no-data corner replaced by the plane through the other three
    assign n_cnt       = 3'(n_reg[0]) + 3'(n_reg[1]) + 3'(n_reg[2]) + 3'(n_reg[3]);
    assign nodata_next = (n_cnt >= 3'd2);
    assign e0 = n_reg[0] ? p_reg[1] + p_reg[2] - p_reg[3] : p_reg[0];
    assign e1 = n_reg[1] ? p_reg[3] + p_reg[0] - p_reg[2] : p_reg[1];
    assign e2 = n_reg[2] ? p_reg[0] + p_reg[3] - p_reg[1] : p_reg[2];
    assign e3 = n_reg[3] ? p_reg[2] + p_reg[1] - p_reg[0] : p_reg[3];

    // shared multiplier operands
    always_comb
    begin
        case (phase_reg)
            3'd0:
            begin
                mul_a = W_ONE - brs_pkg::WF_W'(fx_reg);
                mul_b = brs_pkg::B_W'(p_reg[0]);
            end
            3'd1:
            begin
                mul_a = brs_pkg::WF_W'(fx_reg);
                mul_b = brs_pkg::B_W'(p_reg[1]);
            end
            3'd2:
            begin
                mul_a = W_ONE - brs_pkg::WF_W'(fx_reg);
                mul_b = brs_pkg::B_W'(p_reg[2]);
            end
            3'd3:
            begin
                mul_a = brs_pkg::WF_W'(fx_reg);
                mul_b = brs_pkg::B_W'(p_reg[3]);
            end
            3'd4:
            begin
                mul_a = W_ONE - brs_pkg::WF_W'(fy_reg);
                mul_b = top_reg;
            end
            3'd5:
            begin
                mul_a = brs_pkg::WF_W'(fy_reg);
                mul_b = bot_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mj      = phase_reg - 3'd1;
    assign acc_sum = acc_reg + brs_pkg::ACC_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        // capture the query
        if (query_acc)
        begin
            col_reg <= col;
            row_reg <= row;
        end
        // integer part and fraction, clamped to the last source column or row; zero for a one-wide output
        if (state_reg == brs_pkg::ST_POST)
        begin
            if (dc <= SW'(1))
            begin
                x1_reg <= '0;
                fx_reg <= '0;
            end
            else if (ix > brs_pkg::NUM_W'(sc_m1))
            begin
                x1_reg <= sc_m1;
                fx_reg <= '0;
            end
            else
            begin
                x1_reg <= CW'(ix);
                fx_reg <= qx[brs_pkg::FRAC_BITS-1:0];
            end
            if (dr <= SW'(1))
            begin
                y1_reg <= '0;
                fy_reg <= '0;
            end
            else if (iy > brs_pkg::NUM_W'(sr_m1))
            begin
                y1_reg <= sr_m1;
                fy_reg <= '0;
            end
            else
            begin
                y1_reg <= CW'(iy);
                fy_reg <= qy[brs_pkg::FRAC_BITS-1:0];
            end
        end
        // corner data arrives in the cycle after its read
        if (state_reg == brs_pkg::ST_READ && phase_reg != 3'd0)
        begin
            p_reg[ck] <= in_img[ck] ?
                {{(brs_pkg::P_W-VW){rd_data_reg[VW-1]}}, rd_data_reg[VW-1:0]} : '0;
            n_reg[ck] <= in_img[ck] && rd_data_reg[VW];
        end
        if (state_reg == brs_pkg::ST_EXTRA)
        begin
            nodata_reg <= nodata_next;
            val_reg    <= '0;
            p_reg[0]   <= e0;
            p_reg[1]   <= e1;
            p_reg[2]   <= e2;
            p_reg[3]   <= e3;
        end
        // multiply, then accumulate in the following cycle
        if (state_reg == brs_pkg::ST_MUL)
        begin
            if (phase_reg < 3'd6)
                prod_reg <= $signed({1'b0, mul_a}) * mul_b;
            if (phase_reg != 3'd0)
            begin
                if (!mj[0])
                    acc_reg <= brs_pkg::ACC_W'(prod_reg);
                else if (mj == 3'd1)
                    top_reg <= brs_pkg::round_frac(acc_sum);
                else if (mj == 3'd3)
                    bot_reg <= brs_pkg::round_frac(acc_sum);
                else
                    val_reg <= brs_pkg::round_frac(acc_sum);
            end
        end
    end

    // output register
    logic                 out_valid_reg;
    logic signed [VW-1:0] res_value_reg;
    logic                 res_nodata_reg;
    logic [CW-1:0]        res_col_reg, res_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_value_reg  <= nodata_reg ? '0 : brs_pkg::sat_val(val_reg);
            res_nodata_reg <= nodata_reg;
            res_col_reg    <= col_reg;
            res_row_reg    <= row_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_value  = res_value_reg;
    assign result_nodata = res_nodata_reg;
    assign result_col    = res_col_reg;
    assign result_row    = res_row_reg;

    // checks
    a_query_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        query_acc |=> state_reg == brs_pkg::ST_DIV)
        else $error("query did not start the divide");

    a_post_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == brs_pkg::ST_POST |-> !busy_x && !busy_y)
        else $error("position used before divide finished");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> out_valid_reg && state_reg == brs_pkg::ST_IDLE)
        else $error("result not presented");

    a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_nodata |-> result_value == '0)
        else $error("no-data result carries a value");

endmodule

`default_nettype wire

// ===== verif/tb_bilinear_resampler_nodata.sv =====
// ----------------------------------------------------------------------------
// tb_bilinear_resampler_nodata
// Self-checking bench for the bilinear resampler with no-data handling.
// Each phase programs the registers over apb while the block is idle. It then
// fills the source region and sends a mix of loads and queries. A scoreboard
// keeps its own copy of the image store and predicts every query result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bilinear_resampler_nodata;

    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 100;
    localparam int HOLD_CYCLES = 400;
    localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VMIN = 32'sh8000_0000;

    typedef struct {
        brs_pkg::op_t       op;
        logic [7:0]         c;
        logic [7:0]         r;
        logic signed [31:0] v;
        logic               nd;
    } pixel_txn_t;

    typedef struct {
        logic signed [31:0] v;
        logic               nd;
        logic [7:0]         c;
        logic [7:0]         r;
    } out_pixel_t;

    // scoreboard: image store copy, register copy and pending output pixels
    class resample_scoreboard;
        int         img_val [65536];
        bit         img_nd  [65536];
        int         src_cols = 256, src_rows = 256, dst_cols = 256, dst_rows = 256;
        bit         mask_en;
        int         mask_lo, mask_hi;
        out_pixel_t pending [$];
        int         errors;

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        function int clamp_size(int v, int cap);
            if (v == 0)
                return 1;
            return (v > cap) ? cap : v;
        endfunction

        function void position(int idx, int s, int d, output int ip, output longint fp);
            longint num, i, f;
            i = 0;
            f = 0;
            if (d > 1)
            begin
                num = longint'(idx) * (s - 1);
                i = num / (d - 1);
                f = ((num % (d - 1)) << brs_pkg::FRAC_BITS) / (d - 1);
            end
            if (i >= s - 1)
            begin
                if (i > s - 1)
                    f = 0;
                i = s - 1;
            end
            ip = int'(i);
            fp = f;
        endfunction

        function void fetch(int x, int y, int sc, int sr, output longint v, output int nd);
            if (x >= sc || y >= sr)
            begin
                v = 0;
                nd = 0;
            end
            else
            begin
                v = img_val[y * brs_pkg::MAX_COLS + x];
                nd = img_nd[y * brs_pkg::MAX_COLS + x];
            end
        endfunction

        function longint round_half(longint v);
            return (v + (64'sd1 <<< (brs_pkg::FRAC_BITS - 1))) >>> brs_pkg::FRAC_BITS;
        endfunction

        function void note_input(pixel_txn_t t);
            int         sc, sr, x1, y1, n11, n12, n21, n22;
            longint     fx, fy, p11, p12, p21, p22, top, bot, val, w;
            out_pixel_t o;
            if (t.op == brs_pkg::OP_LOAD)
            begin
                img_val[t.r * brs_pkg::MAX_COLS + t.c] = t.v;
                img_nd[t.r * brs_pkg::MAX_COLS + t.c] = t.nd ||
                    (mask_en && t.v >= mask_lo && t.v <= mask_hi);
                return;
            end
            sc = clamp_size(src_cols, brs_pkg::MAX_COLS);
            sr = clamp_size(src_rows, brs_pkg::MAX_ROWS);
            position(t.c, sc, clamp_size(dst_cols, 511), x1, fx);
            position(t.r, sr, clamp_size(dst_rows, 511), y1, fy);
            fetch(x1, y1, sc, sr, p11, n11);
            fetch(x1 + 1, y1, sc, sr, p21, n21);
            fetch(x1, y1 + 1, sc, sr, p12, n12);
            fetch(x1 + 1, y1 + 1, sc, sr, p22, n22);
            o.c = t.c;
            o.r = t.r;
            o.v = 0;
            o.nd = (n11 + n12 + n21 + n22) >= 2;
            if (!o.nd)
            begin
                // single missing corner comes from the plane through the rest
                if (n11) p11 = p21 + p12 - p22;
                if (n12) p12 = p11 + p22 - p21;
                if (n21) p21 = p22 + p11 - p12;
                if (n22) p22 = p12 + p21 - p11;
                w = 64'sd1 <<< brs_pkg::FRAC_BITS;
                top = round_half((w - fx) * p11 + fx * p21);
                bot = round_half((w - fx) * p12 + fx * p22);
                val = round_half((w - fy) * top + fy * bot);
                if (val > longint'(VMAX)) val = VMAX;
                if (val < longint'(VMIN)) val = VMIN;
                o.v = val[31:0];
            end
            pending.push_back(o);
        endfunction

        task check_result(out_pixel_t got);
            out_pixel_t e;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected pixel (%0d,%0d)", got.c, got.r));
                return;
            end
            e = pending.pop_front();
            if (got.c !== e.c || got.r !== e.r)
                report_mismatch($sformatf("position (%0d,%0d) want (%0d,%0d)",
                                          got.c, got.r, e.c, e.r));
            if (got.nd !== e.nd)
                report_mismatch($sformatf("nodata %0b want %0b at (%0d,%0d)",
                                          got.nd, e.nd, e.c, e.r));
            if (got.v !== e.v)
                report_mismatch($sformatf("value %0d want %0d at (%0d,%0d)",
                                          got.v, e.v, e.c, e.r));
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        psel, penable, pwrite;
    logic [brs_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        in_valid, in_stall;
    logic                        operation;
    logic [7:0]                  col, row;
    logic signed [31:0]          pixel_value;
    logic                        pixel_nodata;
    logic                        out_valid, out_stall;
    logic signed [31:0]          result_value;
    logic                        result_nodata;
    logic [7:0]                  result_col, result_row;

    resample_scoreboard  sb;
    pixel_txn_t          txn_q [$];
    int                  send_idle_pct, recv_idle_pct;
    bit                  hold_req;
    bit                  hold_arm;
    int                  idle_cycles;

    bilinear_resampler_nodata DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .col(col), .row(row), .pixel_value(pixel_value), .pixel_nodata(pixel_nodata),
        .out_valid(out_valid), .out_stall(out_stall), .result_value(result_value),
        .result_nodata(result_nodata), .result_col(result_col), .result_row(result_row)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // monitors on both channels, sampled at the rising edge
    always @(posedge clk)
    begin
        pixel_txn_t t;
        out_pixel_t o;
        if (rst_n && in_valid && !in_stall)
        begin
            t.op = brs_pkg::op_t'(operation);
            t.c = col;
            t.r = row;
            t.v = pixel_value;
            t.nd = pixel_nodata;
            sb.note_input(t);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            o.v = result_value;
            o.nd = result_nodata;
            o.c = result_col;
            o.r = result_row;
            sb.check_result(o);
        end
    end

    // watchdog on cycles with no transaction on any port
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: random stall, plus a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // apb register write, setup then access
    task write_reg(brs_pkg::reg_idx_t idx, logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = brs_pkg::PADDR_W'(4 * int'(idx));
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        case (idx)
            brs_pkg::REG_SRC_COLS:  sb.src_cols = data[8:0];
            brs_pkg::REG_SRC_ROWS:  sb.src_rows = data[8:0];
            brs_pkg::REG_DST_COLS:  sb.dst_cols = data[8:0];
            brs_pkg::REG_DST_ROWS:  sb.dst_rows = data[8:0];
            brs_pkg::REG_MASK_EN:   sb.mask_en = data[0];
            brs_pkg::REG_MASK_LOW:  sb.mask_lo = data;
            brs_pkg::REG_MASK_HIGH: sb.mask_hi = data;
            default: ;
        endcase
    endtask

    task program_regs(int sc, int sr, int dc, int dr, bit men, int mlo, int mhi);
        write_reg(brs_pkg::REG_SRC_COLS, sc);
        write_reg(brs_pkg::REG_SRC_ROWS, sr);
        write_reg(brs_pkg::REG_DST_COLS, dc);
        write_reg(brs_pkg::REG_DST_ROWS, dr);
        write_reg(brs_pkg::REG_MASK_EN, 32'(men));
        write_reg(brs_pkg::REG_MASK_LOW, mlo);
        write_reg(brs_pkg::REG_MASK_HIGH, mhi);
    endtask

    // send every queued transaction, with random gaps before each
    task drive_txns();
        pixel_txn_t t;
        while (txn_q.size() > 0)
        begin
            t = txn_q.pop_front();
            @(negedge clk);
            // long receiver hold-off starts with the first query of an armed phase
            if (hold_arm && t.op == brs_pkg::OP_QUERY)
            begin
                hold_arm = 1'b0;
                hold_req = 1'b1;
            end
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
            in_valid = 1'b1;
            operation = t.op;
            col = t.c;
            row = t.r;
            pixel_value = t.v;
            pixel_nodata = t.nd;
            do
                @(posedge clk);
            while (in_stall);
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // all results in, then let the block settle
    task drain();
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function void push_txn(brs_pkg::op_t op, int c, int r, int v, bit nd);
        pixel_txn_t t;
        t.op = op;
        t.c = 8'(c);
        t.r = 8'(r);
        t.v = v;
        t.nd = nd;
        txn_q.push_back(t);
    endfunction

    function int pick_value(int mlo, int mhi);
        case ($urandom_range(0, 6))
            0:       return VMAX;
            1:       return VMIN;
            2:       return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            3:       return (mhi >= mlo && mhi - mlo >= 0) ? mlo + $urandom_range(0, 3) : 0;
            4:       return 0;
            default: return $urandom;
        endcase
    endfunction

    // one phase: registers, fill of the source region, random mix
    task run_phase(int sc, int sr, int dc, int dr, bit men, int mlo, int mhi, int n);
        int esc, esr, edc, edr;
        drain();
        program_regs(sc, sr, dc, dr, men, mlo, mhi);
        esc = sb.clamp_size(sc, brs_pkg::MAX_COLS);
        esr = sb.clamp_size(sr, brs_pkg::MAX_ROWS);
        edc = sb.clamp_size(dc, 511);
        edr = sb.clamp_size(dr, 511);
        for (int y = 0; y < esr; y++)
            for (int x = 0; x < esc; x++)
                push_txn(brs_pkg::OP_LOAD, x, y, pick_value(mlo, mhi),
                         $urandom_range(0, 99) < 12);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                if ($urandom_range(0, 4) == 0)
                    push_txn(brs_pkg::OP_QUERY, $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom, $urandom_range(0, 1) == 1);
                else
                    push_txn(brs_pkg::OP_QUERY,
                             $urandom_range(0, (edc > 256 ? 256 : edc) - 1),
                             $urandom_range(0, (edr > 256 ? 256 : edr) - 1),
                             $urandom, $urandom_range(0, 1) == 1);
            end
            else if ($urandom_range(0, 4) == 0)
                push_txn(brs_pkg::OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                         pick_value(mlo, mhi), $urandom_range(0, 99) < 12);
            else
                push_txn(brs_pkg::OP_LOAD, $urandom_range(0, esc - 1),
                         $urandom_range(0, esr - 1),
                         pick_value(mlo, mhi), $urandom_range(0, 99) < 12);
        end
        drive_txns();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        operation = brs_pkg::OP_LOAD;
        col = '0;
        row = '0;
        pixel_value = '0;
        pixel_nodata = 1'b0;
        hold_req = 1'b0;
        hold_arm = 1'b0;
        idle_cycles = 0;
        send_idle_pct = 7;
        recv_idle_pct = 67;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: 4x3 source, 7x5 output, mask over [-100, 100]
        program_regs(4, 3, 7, 5, 1'b1, -100, 100);
        push_txn(brs_pkg::OP_LOAD, 0, 0, VMAX, 0);
        push_txn(brs_pkg::OP_LOAD, 1, 0, VMAX, 0);
        push_txn(brs_pkg::OP_LOAD, 2, 0, VMIN, 0);
        push_txn(brs_pkg::OP_LOAD, 3, 0, 1000, 0);
        push_txn(brs_pkg::OP_LOAD, 0, 1, VMAX, 0);
        push_txn(brs_pkg::OP_LOAD, 1, 1, VMAX, 0);
        push_txn(brs_pkg::OP_LOAD, 2, 1, -5, 0);
        push_txn(brs_pkg::OP_LOAD, 3, 1, 12345, 0);
        push_txn(brs_pkg::OP_LOAD, 0, 2, 32'h1234_5678, 0);
        push_txn(brs_pkg::OP_LOAD, 1, 2, -70000, 0);
        push_txn(brs_pkg::OP_LOAD, 2, 2, VMIN, 0);
        push_txn(brs_pkg::OP_LOAD, 3, 2, 65536, 0);
        push_txn(brs_pkg::OP_LOAD, 255, 255, VMIN, 1);
        push_txn(brs_pkg::OP_QUERY, 0, 0, 0, 0);
        push_txn(brs_pkg::OP_QUERY, 1, 1, 0, 0);
        push_txn(brs_pkg::OP_QUERY, 6, 4, 0, 0);
        push_txn(brs_pkg::OP_QUERY, 3, 2, 0, 0);
        push_txn(brs_pkg::OP_QUERY, 5, 1, 0, 0);
        push_txn(brs_pkg::OP_QUERY, 2, 3, 0, 0);
        push_txn(brs_pkg::OP_QUERY, 255, 255, VMAX, 1);
        push_txn(brs_pkg::OP_LOAD, 2, 2, 77, 1);
        push_txn(brs_pkg::OP_QUERY, 4, 2, 0, 0);
        push_txn(brs_pkg::OP_QUERY, 4, 3, 0, 0);
        drive_txns();

        // random phases with varied geometry; idling pattern changes after the fourth and seventh phase
        run_phase(9, 7, 33, 17, 1'b0, 0, 0, 60);
        hold_arm = 1'b1;
        run_phase(16, 8, 31, 9, 1'b1, -65536, 65536, 60);
        run_phase(256, 1, 511, 1, 1'b1, VMIN, VMAX, 50);
        run_phase(0, 0, 0, 0, 1'b0, 0, 0, 30);
        send_idle_pct = 67;
        recv_idle_pct = 7;
        run_phase(1, 256, 1, 256, 1'b0, VMAX, VMAX, 50);
        run_phase(300, 1, 2, 300, 1'b1, 0, 1 << 20, 50);
        run_phase(5, 9, 256, 2, 1'b1, VMIN, VMIN + 3, 50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(2, 2, 256, 256, 1'b0, 0, 0, 50);
        run_phase(12, 10, 5, 23, 1'b1, -100, 100, 50);
        hold_arm = 1'b1;
        run_phase(8, 13, 8, 13, 1'b0, 0, 0, 50);
        drain();

        if (sb.pending.size() > 0)
            sb.report_mismatch($sformatf("%0d output pixels never arrived",
                                         sb.pending.size()));
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
